@@ rtl/core/inps_pkg.sv @@
// types and constants shared by the interval nearest point store
// no dependencies
package inps_pkg;

   localparam int PointWidth = 34;
   localparam int DistWidth  = 33;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [DistWidth-1:0] DIST_SAT = {DistWidth{1'b1}};

   typedef struct packed {
      logic               command;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } req_type;

   typedef struct packed {
      logic [DistWidth-1:0] distance;
      logic                 store_empty;
      logic                 overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_A,
      ST_SCAN_A,
      ST_COMMIT_A,
      ST_START_B,
      ST_SCAN_B,
      ST_COMMIT_B,
      ST_QRY_START,
      ST_QRY_SCAN,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic use_b;
      logic scan;
      logic commit;
      logic rsp_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } ctl_sts_type;

endpackage

@@ rtl/core/inps_ctrl.sv @@
// controller state machine sequencing insert scans, query scans and results
// depends on inps_pkg
module inps_ctrl import inps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_stall,
   output ctl_cmd_type cmd,
   input  ctl_sts_type sts
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == CMD_QUERY) ? ST_QRY_START : ST_START_A;
            end
         end
         ST_START_A:   state_in = ST_SCAN_A;
         ST_SCAN_A:    if (sts.scan_done) state_in = ST_COMMIT_A;
         ST_COMMIT_A:  state_in = ST_START_B;
         ST_START_B:   state_in = ST_SCAN_B;
         ST_SCAN_B:    if (sts.scan_done) state_in = ST_COMMIT_B;
         ST_COMMIT_B:  state_in = ST_IDLE;
         ST_QRY_START: state_in = ST_QRY_SCAN;
         ST_QRY_SCAN:  if (sts.scan_done) state_in = ST_RESULT;
         ST_RESULT:    if (sts.rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_START_A:   cmd.clear = 1'b1;
         ST_START_B: begin
            cmd.clear = 1'b1;
            cmd.use_b = 1'b1;
         end
         ST_QRY_START: cmd.clear = 1'b1;
         ST_SCAN_A,
         ST_SCAN_B,
         ST_QRY_SCAN:  cmd.scan = 1'b1;
         ST_COMMIT_A,
         ST_COMMIT_B:  cmd.commit = 1'b1;
         ST_RESULT:    cmd.rsp_load = sts.rsp_free;
         default:      cmd = '0;
      endcase
   end

endmodule

@@ rtl/core/inps_dp.sv @@
// datapath: point memory, scan pipeline, match and minimum distance, output register
// depends on inps_pkg
module inps_dp import inps_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   logic signed [PointWidth-1:0] mem [CAPACITY];

   logic signed [PointWidth-1:0] pt_a_ff, pt_b_ff;
   logic signed [31:0]           lo_ff, hi_ff;
   logic                         use_b_ff;
   logic [CW-1:0]                count_ff;
   logic                         ovf_ff;
   logic [CW-1:0]                idx_ff;
   logic signed [PointWidth-1:0] rd_data_ff;
   logic                         rd_vld_ff;
   logic [DistWidth-1:0]         dist_ff;
   logic                         dist_vld_ff;
   logic                         found_ff;
   logic [DistWidth-1:0]         best_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_ff;

   logic signed [PointWidth-1:0] pt_a_in, pt_b_in, cur_pt;
   logic                         issue;
   logic                         full;
   logic signed [PointWidth:0]   p_ext, lo_ext, hi_ext, diff_lo, diff_hi;
   logic [DistWidth-1:0]         dist_in;
   logic                         rsp_free;

   always_comb begin
      pt_a_in = PointWidth'(req_data.x) - PointWidth'(req_data.y);
      pt_b_in = PointWidth'(req_data.x) + PointWidth'(req_data.y);
      cur_pt  = use_b_ff ? pt_b_ff : pt_a_ff;
      issue   = cmd.scan && (idx_ff < count_ff);
      full    = (count_ff == CapCount);
   end

   // distance of the entry just read to [lo,hi]
   always_comb begin
      p_ext   = (PointWidth+1)'(rd_data_ff);
      lo_ext  = (PointWidth+1)'(lo_ff);
      hi_ext  = (PointWidth+1)'(hi_ff);
      diff_lo = lo_ext - p_ext;
      diff_hi = p_ext - hi_ext;
      if (p_ext < lo_ext) begin
         dist_in = diff_lo[DistWidth-1:0];
      end else if (p_ext > hi_ext) begin
         dist_in = diff_hi[DistWidth-1:0];
      end else begin
         dist_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_a_ff <= pt_a_in;
         pt_b_ff <= pt_b_in;
         lo_ff   <= (req_data.x < req_data.y) ? req_data.x : req_data.y;
         hi_ff   <= (req_data.x < req_data.y) ? req_data.y : req_data.x;
      end
      if (cmd.clear) begin
         use_b_ff <= cmd.use_b;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !found_ff && !full) begin
         mem[count_ff[AW-1:0]] <= cur_pt;
      end
      rd_data_ff <= mem[idx_ff[AW-1:0]];
      dist_ff    <= dist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         idx_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         dist_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         best_ff     <= DIST_SAT;
      end else begin
         rd_vld_ff   <= issue;
         dist_vld_ff <= rd_vld_ff;
         if (cmd.clear) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            best_ff  <= DIST_SAT;
         end else begin
            if (issue) begin
               idx_ff <= idx_ff + CW'(1);
            end
            if (rd_vld_ff && (rd_data_ff == cur_pt)) begin
               found_ff <= 1'b1;
            end
            if (dist_vld_ff && (dist_ff < best_ff)) begin
               best_ff <= dist_ff;
            end
         end
         // a repeat is skipped, a new point on a full store is dropped
         if (cmd.commit && !found_ff) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.distance    <= best_ff;
         rsp_ff.store_empty <= (count_ff == '0);
         rsp_ff.overflowed  <= ovf_ff;
      end
   end

   always_comb begin
      sts.scan_done = (idx_ff >= count_ff) && !rd_vld_ff && !dist_vld_ff;
      sts.rsp_free  = rsp_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/interval_nearest_point_store.sv @@
// interval nearest point store: bounded set of signed points, nearest distance to an interval
// an insert scans the point memory twice, once for each of its two points, a query once;
// each scan reads the point memory one entry per cycle through its single read port,
// and a new item is taken only once the store is back idle after the last one
// synchronous reset empties the store and clears the overflow flag; memory is not cleared
module interval_nearest_point_store import inps_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   inps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   inps_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for interval_nearest_point_store: directed table, then random
// inserts and interval queries checked against an in-bench nearest-distance model
// depends on inps_pkg and the interval_nearest_point_store rtl
`timescale 1ns / 1ps

module tb_top;
   import inps_pkg::*;

   // full capacity; the fill phase inserts fresh point pairs so the store fills in the run
   localparam int CAPACITY    = 1024;
   localparam int ITEMS       = 580;
   localparam int TAIL_ITEMS  = 24;
   localparam int QUIET_TAIL  = 16;
   localparam int STALL_LIMIT = 12000;
   localparam int DRAIN       = 2 * (CAPACITY + 4) + 20;

   localparam logic signed [31:0] XMIN = 32'sh8000_0000;
   localparam logic signed [31:0] XMAX = 32'sh7fff_ffff;

   localparam rsp_type ANS_EMPTY  = '{DIST_SAT, 1'b1, 1'b0};
   localparam rsp_type ANS_INSIDE = '{'0, 1'b0, 1'b0};

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type answer;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // model of the store
   longint  held_points [CAPACITY];
   int      held_count    = 0;
   bit      overflow_seen = 1'b0;

   rsp_type      pending_answers [$];
   req_type      insert_history [$];
   stim_row_type plan [$];

   int mismatches      = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int queries_sent    = 0;
   int idle_cycles     = 0;
   bit quiet           = 1'b0;

   interval_nearest_point_store #(.CAPACITY(CAPACITY)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit is_held(longint p);
      for (int i = 0; i < held_count; i++) begin
         if (held_points[i] == p) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void add_held(longint p);
      if (is_held(p)) return;
      if (held_count >= CAPACITY) begin
         overflow_seen = 1'b1;
         return;
      end
      held_points[held_count] = p;
      held_count++;
   endfunction

   function automatic rsp_type nearest_answer(logic signed [31:0] a, logic signed [31:0] b);
      longint  lo;
      longint  hi;
      longint  d;
      longint  best;
      rsp_type r;
      lo   = (a < b) ? longint'(a) : longint'(b);
      hi   = (a < b) ? longint'(b) : longint'(a);
      best = longint'(DIST_SAT);
      for (int i = 0; i < held_count; i++) begin
         if (held_points[i] < lo) d = lo - held_points[i];
         else if (held_points[i] > hi) d = held_points[i] - hi;
         else d = 0;
         if (d < best) best = d;
      end
      r.distance    = best[DistWidth-1:0];
      r.store_empty = (held_count == 0);
      r.overflowed  = overflow_seen;
      return r;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > longint'(XMAX)) return XMAX;
      if (v < longint'(XMIN)) return XMIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] pick_value();
      longint p;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? XMAX : XMIN;
         1: return 32'(int'($urandom_range(0, 400)) - 200);
         2, 3: begin
            // land near a held point so distances stay small and often hit zero
            if (held_count > 0) begin
               p = held_points[$urandom_range(0, held_count - 1)]
                   + longint'(int'($urandom_range(0, 40)) - 20);
               return clamp32(p);
            end
         end
         default: ;
      endcase
      return $urandom;
   endfunction

   function automatic req_type random_insert();
      req_type r;
      if (insert_history.size() > 0 && $urandom_range(0, 4) == 0)
         return insert_history[$urandom_range(0, insert_history.size() - 1)];
      r.command = CMD_INSERT;
      r.x       = pick_value();
      r.y       = ($urandom_range(0, 7) == 0) ? 32'sd0 : pick_value();
      // one slot left: a zero offset gives a single point, so the store fills exactly
      if (held_count == CAPACITY - 1) r.y = '0;
      return r;
   endfunction

   // fresh points only; a single fresh point when one slot is left
   function automatic req_type fill_insert();
      req_type r;
      r.command = CMD_INSERT;
      do begin
         r.x = pick_value();
         r.y = (held_count == CAPACITY - 1) ? 32'sd0 : pick_value();
      end while (is_held(longint'(r.x) - longint'(r.y)) ||
                 is_held(longint'(r.x) + longint'(r.y)));
      return r;
   endfunction

   function automatic req_type random_query();
      req_type r;
      r.command = CMD_QUERY;
      r.x       = pick_value();
      r.y       = $urandom_range(0, 1) ?
                  clamp32(longint'(r.x) + longint'($urandom_range(0, 64))) : pick_value();
      return r;
   endfunction

   function automatic stim_row_type make_row(logic cmd, logic signed [31:0] a,
                                             logic signed [31:0] b, bit typed = 1'b0,
                                             rsp_type answer = '0);
      stim_row_type r;
      r.item.command = cmd;
      r.item.x       = a;
      r.item.y       = b;
      r.typed        = typed;
      r.answer       = answer;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic send_item(input req_type item, input bit typed = 1'b0,
                            input rsp_type answer = '0);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (item.command == CMD_QUERY) begin
         pending_answers.push_back(typed ? answer : nearest_answer(item.x, item.y));
         queries_sent++;
      end else begin
         add_held(longint'(item.x) - longint'(item.y));
         add_held(longint'(item.x) + longint'(item.y));
         insert_history.push_back(item);
      end
   endtask

   // result side: random stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result with no query pending: dist=%0d empty=%0b ovf=%0b",
                                      rsp_data.distance, rsp_data.store_empty,
                                      rsp_data.overflowed));
         end else begin
            want = pending_answers.pop_front();
            results_checked++;
            if (rsp_data.distance !== want.distance)
               report_mismatch($sformatf("distance %0d, want %0d",
                                         rsp_data.distance, want.distance));
            if (rsp_data.store_empty !== want.store_empty)
               report_mismatch($sformatf("store_empty %0b, want %0b",
                                         rsp_data.store_empty, want.store_empty));
            if (rsp_data.overflowed !== want.overflowed)
               report_mismatch($sformatf("overflowed %0b, want %0b",
                                         rsp_data.overflowed, want.overflowed));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type fresh;
      int      tail_end;

      // empty store, extremes, zero offset, reversed bounds, repeats
      plan.push_back(make_row(CMD_QUERY,  0, 0, 1'b1, ANS_EMPTY));
      plan.push_back(make_row(CMD_QUERY,  5, -5, 1'b1, ANS_EMPTY));
      plan.push_back(make_row(CMD_INSERT, 0, 0));
      plan.push_back(make_row(CMD_QUERY,  0, 0, 1'b1, ANS_INSIDE));
      plan.push_back(make_row(CMD_INSERT, XMAX, XMIN));
      plan.push_back(make_row(CMD_INSERT, XMIN, XMAX));
      plan.push_back(make_row(CMD_INSERT, XMIN, XMIN));
      plan.push_back(make_row(CMD_INSERT, XMAX, XMAX));
      plan.push_back(make_row(CMD_QUERY,  XMIN, XMIN));
      plan.push_back(make_row(CMD_QUERY,  XMAX, XMAX));
      plan.push_back(make_row(CMD_QUERY,  XMIN, XMAX, 1'b1, ANS_INSIDE));
      plan.push_back(make_row(CMD_QUERY,  XMAX, XMIN, 1'b1, ANS_INSIDE));
      plan.push_back(make_row(CMD_INSERT, 100, 7));
      plan.push_back(make_row(CMD_QUERY,  95, 105));
      plan.push_back(make_row(CMD_QUERY,  105, 95));
      plan.push_back(make_row(CMD_QUERY,  100, 100));
      plan.push_back(make_row(CMD_INSERT, 100, 7));
      plan.push_back(make_row(CMD_INSERT, -100, -7));
      plan.push_back(make_row(CMD_QUERY,  -50, -50));
      plan.push_back(make_row(CMD_INSERT, 3, 0));
      plan.push_back(make_row(CMD_QUERY,  3, 3, 1'b1, ANS_INSIDE));
      plan.push_back(make_row(CMD_QUERY,  1000, 2000));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].answer);

      // grow the store up to exactly full
      while (held_count < CAPACITY) begin
         if ($urandom_range(0, 15) == 0) send_item(random_query());
         else send_item(fill_insert());
      end

      // a repeat into a full store is not a drop, a fresh point is
      send_item(insert_history[$urandom_range(0, insert_history.size() - 1)]);
      send_item(random_query());
      do fresh = random_insert();
      while (is_held(longint'(fresh.x) - longint'(fresh.y)) &&
             is_held(longint'(fresh.x) + longint'(fresh.y)));
      send_item(fresh);
      send_item(random_query());

      // full store, sticky flag set
      tail_end = (items_sent + TAIL_ITEMS > ITEMS) ? items_sent + TAIL_ITEMS : ITEMS;
      while (items_sent < tail_end) begin
         quiet = (tail_end - items_sent <= QUIET_TAIL);
         if ($urandom_range(0, 1)) send_item(random_query());
         else send_item(random_insert());
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("run covered %0d items, %0d interval queries, %0d results checked",
               items_sent, queries_sent, results_checked);
      $display("store held %0d of %0d points, overflow flag reached %0b",
               held_count, CAPACITY, overflow_seen);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/inps_pkg.sv
rtl/core/inps_ctrl.sv
rtl/core/inps_dp.sv
rtl/core/interval_nearest_point_store.sv
tb/tb_top.sv
